// ----- rtl/core/ngh_pkg.sv -----
`timescale 1ns / 1ps

package ngh_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int COEFF_WIDTH  = 16;
   localparam int ENV_FRAC     = 8;
   localparam int ENV_WIDTH    = SAMPLE_WIDTH + ENV_FRAC;
   localparam int GAIN_WIDTH   = COEFF_WIDTH + 1;
   localparam int HOLD_WIDTH   = COEFF_WIDTH + 1;

   // shared multiplier: signed A by signed B (B is always non-negative)
   localparam int MUL_A_WIDTH  = ENV_WIDTH + 2;
   localparam int MUL_B_WIDTH  = GAIN_WIDTH + 1;
   localparam int PROD_WIDTH   = MUL_A_WIDTH + MUL_B_WIDTH;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = GAIN_WIDTH;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = 1;
   localparam int QCOUNT_WIDTH = QPTR_WIDTH + 1;

   localparam logic [GAIN_WIDTH-1:0]  UNITY_GAIN = GAIN_WIDTH'(1) << COEFF_WIDTH;
   localparam logic [PROD_WIDTH-1:0]  ROUND_HALF = PROD_WIDTH'(1) << (COEFF_WIDTH - 1);
   localparam logic [HOLD_WIDTH-1:0]  HOLD_MAX   = {HOLD_WIDTH{1'b1}};

   localparam logic [SAMPLE_WIDTH-1:0] RST_THRESHOLD    = SAMPLE_WIDTH'(328);
   localparam logic [GAIN_WIDTH-1:0]   RST_RANGE_GAIN   = GAIN_WIDTH'(7);
   localparam logic [COEFF_WIDTH-1:0]  RST_ATTACK       = COEFF_WIDTH'(64066);
   localparam logic [COEFF_WIDTH-1:0]  RST_RELEASE      = COEFF_WIDTH'(65521);
   localparam logic [COEFF_WIDTH-1:0]  RST_ENV_RISE     = COEFF_WIDTH'(6790);
   localparam logic [COEFF_WIDTH-1:0]  RST_ENV_FALL     = COEFF_WIDTH'(65506);
   localparam logic [COEFF_WIDTH-1:0]  RST_HOLD_SAMPLES = COEFF_WIDTH'(2205);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_THRESHOLD    = 3'd0,
      CSR_RANGE_GAIN   = 3'd1,
      CSR_ATTACK       = 3'd2,
      CSR_RELEASE      = 3'd3,
      CSR_ENV_RISE     = 3'd4,
      CSR_ENV_FALL     = 3'd5,
      CSR_HOLD_SAMPLES = 3'd6
   } ngh_csr_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] threshold_level;
      logic [GAIN_WIDTH-1:0]   range_gain;
      logic [COEFF_WIDTH-1:0]  attack_coeff;
      logic [COEFF_WIDTH-1:0]  release_coeff;
      logic [COEFF_WIDTH-1:0]  env_rise_coeff;
      logic [COEFF_WIDTH-1:0]  env_fall_coeff;
      logic [COEFF_WIDTH-1:0]  hold_samples;
   } ngh_cfg_type;

   // classified sample as it travels from front to back
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [SAMPLE_WIDTH-1:0]        mag;
   } ngh_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ngh_qstat_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_GATE      = 3'd1,
      ST_GAIN_MUL  = 3'd2,
      ST_GAIN_UPD  = 3'd3,
      ST_APPLY_MUL = 3'd4,
      ST_OUT       = 3'd5
   } ngh_state_type;

endpackage

// ----- rtl/core/ngh_if.sv -----
`timescale 1ns / 1ps

interface ngh_req_if import ngh_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface ngh_rsp_if import ngh_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           gate_open;

   modport source (output valid, output sample_out, output gate_open, input ready);
   modport sink (input valid, input sample_out, input gate_open, output ready);
endinterface

// ----- rtl/core/ngh_front.sv -----
`timescale 1ns / 1ps

module ngh_front import ngh_pkg::*; (
   ngh_req_if.sink       req,
   input  ngh_qstat_type qstat,
   output logic          push,
   output ngh_item_type  item
);

   logic [SAMPLE_WIDTH-1:0] raw;

   assign raw       = req.sample_in;
   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;

   // two's complement magnitude; full-scale negative stays exact as unsigned
   assign item.sample = req.sample_in;
   assign item.mag    = raw[SAMPLE_WIDTH-1] ? (~raw + SAMPLE_WIDTH'(1)) : raw;

endmodule

// ----- rtl/core/ngh_queue.sv -----
`timescale 1ns / 1ps

module ngh_queue import ngh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ngh_item_type  push_item,
   input  logic          pop,
   output ngh_item_type  head,
   output ngh_qstat_type qstat
);

   ngh_item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == QCOUNT_WIDTH'(QUEUE_DEPTH));
   assign head        = entry_ff[rd_ptr_ff];

   assign do_push = push && !qstat.full;
   assign do_pop  = pop && !qstat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCOUNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCOUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/ngh_back.sv -----
`timescale 1ns / 1ps

module ngh_back import ngh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ngh_cfg_type   cfg,
   input  ngh_item_type  head,
   input  ngh_qstat_type qstat,
   output logic          pop,
   ngh_rsp_if.source     rsp
);

   ngh_state_type state_ff, state_in;

   logic [SAMPLE_WIDTH-1:0]        mag_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [ENV_WIDTH-1:0]           env_ff, env_in;
   logic [GAIN_WIDTH-1:0]          gain_ff, gain_in;
   logic [GAIN_WIDTH-1:0]          target_ff, target_in;
   logic [HOLD_WIDTH-1:0]          hold_ff, hold_in;
   logic                           open_ff, open_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic                           out_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff, out_sample_in;
   logic                           out_gate_ff;

   // decoded per-state controls
   logic                           load_item, load_env, load_target, load_gain, load_out;
   logic signed [MUL_A_WIDTH-1:0]  mul_a;
   logic signed [MUL_B_WIDTH-1:0]  mul_b;
   logic signed [PROD_WIDTH-1:0]   prod;

   logic [ENV_WIDTH-1:0]           head_m, item_m;
   logic [PROD_WIDTH-1:0]          env_sum, gain_sum, out_sum;
   logic [ENV_WIDTH-1:0]           env_new;
   logic                           above;
   logic [HOLD_WIDTH-1:0]          hold_inc;
   logic [GAIN_WIDTH-1:0]          range_lim;
   logic signed [PROD_WIDTH-COEFF_WIDTH-1:0] out_shift;
   logic                           out_slot_free;

   assign head_m = {head.mag, ENV_FRAC'(0)};
   assign item_m = {mag_ff, ENV_FRAC'(0)};

   assign out_slot_free = !out_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               state_in = ST_GATE;
            end
         end
         ST_GATE:      state_in = ST_GAIN_MUL;
         ST_GAIN_MUL:  state_in = ST_GAIN_UPD;
         ST_GAIN_UPD:  state_in = ST_APPLY_MUL;
         ST_APPLY_MUL: state_in = ST_OUT;
         ST_OUT: begin
            if (out_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // per-state outputs and multiplier operand select
   always_comb begin
      pop         = 1'b0;
      load_item   = 1'b0;
      load_env    = 1'b0;
      load_target = 1'b0;
      load_gain   = 1'b0;
      load_out    = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      case (state_ff)
         ST_IDLE: begin
            pop       = !qstat.empty;
            load_item = !qstat.empty;
            // smooth as x + c*(old - x), one product per step
            mul_a = $signed({2'b00, env_ff}) - $signed({2'b00, head_m});
            mul_b = (head_m > env_ff) ? $signed({2'b00, cfg.env_rise_coeff})
                                      : $signed({2'b00, cfg.env_fall_coeff});
         end
         ST_GATE: begin
            load_env = 1'b1;
         end
         ST_GAIN_MUL: begin
            load_target = 1'b1;
            mul_a = $signed(MUL_A_WIDTH'(gain_ff)) - $signed(MUL_A_WIDTH'(target_in));
            mul_b = (target_in > gain_ff) ? $signed({2'b00, cfg.attack_coeff})
                                          : $signed({2'b00, cfg.release_coeff});
         end
         ST_GAIN_UPD: begin
            load_gain = 1'b1;
         end
         ST_APPLY_MUL: begin
            mul_a = MUL_A_WIDTH'(sample_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         ST_OUT: begin
            load_out = out_slot_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // envelope update and gate decision
   always_comb begin
      env_sum  = PROD_WIDTH'({item_m, COEFF_WIDTH'(0)}) + prod_ff + ROUND_HALF;
      env_new  = env_sum[COEFF_WIDTH +: ENV_WIDTH];
      above    = env_new > {cfg.threshold_level, ENV_FRAC'(0)};
      hold_inc = (hold_ff < HOLD_MAX) ? hold_ff + HOLD_WIDTH'(1) : hold_ff;
      env_in   = env_new;
      hold_in  = hold_ff;
      open_in  = open_ff;
      if (above) begin
         hold_in = '0;
         open_in = 1'b1;
      end else if (open_ff) begin
         hold_in = hold_inc;
         if (hold_inc > HOLD_WIDTH'(cfg.hold_samples)) begin
            open_in = 1'b0;
         end
      end
   end

   // gain target and glide
   always_comb begin
      range_lim = (cfg.range_gain > UNITY_GAIN) ? UNITY_GAIN : cfg.range_gain;
      target_in = open_ff ? UNITY_GAIN : range_lim;
      gain_sum  = PROD_WIDTH'({target_ff, COEFF_WIDTH'(0)}) + prod_ff + ROUND_HALF;
      gain_in   = gain_sum[COEFF_WIDTH +: GAIN_WIDTH];
   end

   // round half up, then saturate
   always_comb begin
      out_sum   = prod_ff + ROUND_HALF;
      out_shift = $signed(out_sum[PROD_WIDTH-1:COEFF_WIDTH]);
      if (out_shift > $signed((PROD_WIDTH-COEFF_WIDTH)'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}))) begin
         out_sample_in = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else if (out_shift < -$signed((PROD_WIDTH-COEFF_WIDTH)'({1'b1,
                                         {(SAMPLE_WIDTH-1){1'b0}}}))) begin
         out_sample_in = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         out_sample_in = out_shift[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         gain_ff      <= UNITY_GAIN;
         hold_ff      <= '0;
         open_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_env) begin
            env_ff  <= env_in;
            hold_ff <= hold_in;
            open_ff <= open_in;
         end
         if (load_gain) begin
            gain_ff <= gain_in;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      // output product must survive a stall in ST_OUT
      if (state_ff != ST_OUT) begin
         prod_ff <= prod;
      end
      if (load_item) begin
         mag_ff    <= head.mag;
         sample_ff <= head.sample;
      end
      if (load_target) begin
         target_ff <= target_in;
      end
      if (load_out) begin
         out_sample_ff <= out_sample_in;
         out_gate_ff   <= open_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.sample_out = out_sample_ff;
   assign rsp.gate_open  = out_gate_ff;

endmodule

// ----- rtl/core/noise_gate_hold_attack_release_top.sv -----
`timescale 1ns / 1ps
// A sample taken on req passes the queue, then the back-end states IDLE, GATE, GAIN_MUL,
//   GAIN_UPD, APPLY_MUL and OUT into the rsp register. The sequencer takes a new sample only
//   in IDLE and runs envelope, gain and output products through one shared multiplier.
// A 2-entry queue and the rsp output register let each side stall on its own.
// Reset (synchronous, active high) restores default settings, zero envelope, unity gain,
//   closed gate, and empties the queue and output register.

module noise_gate_hold_attack_release_top import ngh_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   ngh_req_if.sink                    req,
   ngh_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   ngh_cfg_type   cfg_ff, cfg_in;
   ngh_item_type  front_item, head;
   ngh_qstat_type qstat;
   logic          push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD:    cfg_in.threshold_level = csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_RANGE_GAIN:   cfg_in.range_gain      = csr_wdata[GAIN_WIDTH-1:0];
            CSR_ATTACK:       cfg_in.attack_coeff    = csr_wdata[COEFF_WIDTH-1:0];
            CSR_RELEASE:      cfg_in.release_coeff   = csr_wdata[COEFF_WIDTH-1:0];
            CSR_ENV_RISE:     cfg_in.env_rise_coeff  = csr_wdata[COEFF_WIDTH-1:0];
            CSR_ENV_FALL:     cfg_in.env_fall_coeff  = csr_wdata[COEFF_WIDTH-1:0];
            CSR_HOLD_SAMPLES: cfg_in.hold_samples    = csr_wdata[COEFF_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_level <= RST_THRESHOLD;
         cfg_ff.range_gain      <= RST_RANGE_GAIN;
         cfg_ff.attack_coeff    <= RST_ATTACK;
         cfg_ff.release_coeff   <= RST_RELEASE;
         cfg_ff.env_rise_coeff  <= RST_ENV_RISE;
         cfg_ff.env_fall_coeff  <= RST_ENV_FALL;
         cfg_ff.hold_samples    <= RST_HOLD_SAMPLES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ngh_front u_front (
      .req   (req),
      .qstat (qstat),
      .push  (push),
      .item  (front_item)
   );

   ngh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   ngh_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

// ----- tb/tb_noise_gate_hold_attack_release_top.sv -----
`timescale 1ns / 1ps

module tb_noise_gate_hold_attack_release_top;
   import ngh_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 40;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NO_REG = 3'd7;
   localparam logic [63:0] Q16_ONE = 64'd1 << COEFF_WIDTH;
   localparam logic [63:0] Q16_HALF = 64'd1 << (COEFF_WIDTH - 1);

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           gate_open;
   } gated_sample_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   ngh_req_if req_ch();
   ngh_rsp_if rsp_ch();

   noise_gate_hold_attack_release_top uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // gate model state and register copy
   ngh_cfg_type gate_cfg;
   logic [ENV_WIDTH-1:0] env_level;
   logic [GAIN_WIDTH-1:0] gain_level;
   logic [HOLD_WIDTH-1:0] hold_cnt;
   logic gate_is_open;

   gated_sample_type pending_outputs[$];
   int error_count = 0;
   int cycle_count = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;

   function automatic ngh_cfg_type default_cfg();
      ngh_cfg_type c;
      c.threshold_level = RST_THRESHOLD;
      c.range_gain      = RST_RANGE_GAIN;
      c.attack_coeff    = RST_ATTACK;
      c.release_coeff   = RST_RELEASE;
      c.env_rise_coeff  = RST_ENV_RISE;
      c.env_fall_coeff  = RST_ENV_FALL;
      c.hold_samples    = RST_HOLD_SAMPLES;
      return c;
   endfunction

   // one-pole step, c weights the old value
   function automatic logic [63:0] one_pole(input logic [63:0] c, input logic [63:0] old_v,
                                            input logic [63:0] new_v);
      return (c * old_v + (Q16_ONE - c) * new_v + Q16_HALF) >> COEFF_WIDTH;
   endfunction

   function automatic gated_sample_type gate_predict(input logic signed [SAMPLE_WIDTH-1:0] s);
      gated_sample_type r;
      longint sv;
      longint prod;
      longint y;
      logic [63:0] mag;
      logic [63:0] m;
      logic [63:0] rg;
      logic [63:0] target;
      sv = s;
      mag = (sv < 0) ? 64'(-sv) : 64'(sv);
      m = mag << ENV_FRAC;
      if (m > env_level)
         env_level = ENV_WIDTH'(one_pole(gate_cfg.env_rise_coeff, env_level, m));
      else
         env_level = ENV_WIDTH'(one_pole(gate_cfg.env_fall_coeff, env_level, m));

      if (64'(env_level) > (64'(gate_cfg.threshold_level) << ENV_FRAC)) begin
         hold_cnt = '0;
         gate_is_open = 1'b1;
      end else if (gate_is_open) begin
         if (hold_cnt != HOLD_MAX)
            hold_cnt = hold_cnt + 1'b1;
         if (hold_cnt > HOLD_WIDTH'(gate_cfg.hold_samples))
            gate_is_open = 1'b0;
      end

      // range gain above unity acts as unity
      rg = (gate_cfg.range_gain > UNITY_GAIN) ? 64'(UNITY_GAIN) : 64'(gate_cfg.range_gain);
      target = gate_is_open ? 64'(UNITY_GAIN) : rg;
      if (target > gain_level)
         gain_level = GAIN_WIDTH'(one_pole(gate_cfg.attack_coeff, gain_level, target));
      else
         gain_level = GAIN_WIDTH'(one_pole(gate_cfg.release_coeff, gain_level, target));

      prod = sv * longint'(gain_level);
      y = (prod + longint'(Q16_HALF)) >>> COEFF_WIDTH;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.sample_out = y[SAMPLE_WIDTH-1:0];
      r.gate_open = gate_is_open;
      return r;
   endfunction

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample(input int amp);
      int v;
      v = int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      return SAMPLE_WIDTH'(v);
   endfunction

   function automatic ngh_cfg_type random_cfg();
      ngh_cfg_type c;
      c.threshold_level = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 4000));
      c.range_gain      = 17'($urandom);
      c.attack_coeff    = 16'($urandom);
      c.release_coeff   = 16'($urandom);
      c.env_rise_coeff  = 16'($urandom_range(0, 40000));
      c.env_fall_coeff  = 16'($urandom_range(30000, 65535));
      c.hold_samples    = 16'($urandom_range(0, 30));
      return c;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // upper data bit is junk for the 16-bit registers and must be dropped
   task automatic program_regs(input ngh_cfg_type c, input bit stray);
      write_reg(CSR_THRESHOLD, {1'($urandom), c.threshold_level});
      write_reg(CSR_RANGE_GAIN, c.range_gain);
      write_reg(CSR_ATTACK, {1'($urandom), c.attack_coeff});
      if (stray)
         write_reg(CSR_NO_REG, CSR_DATA_WIDTH'($urandom));
      write_reg(CSR_RELEASE, {1'($urandom), c.release_coeff});
      write_reg(CSR_ENV_RISE, {1'($urandom), c.env_rise_coeff});
      write_reg(CSR_ENV_FALL, {1'($urandom), c.env_fall_coeff});
      write_reg(CSR_HOLD_SAMPLES, {1'($urandom), c.hold_samples});
      csr_we <= 1'b0;
      gate_cfg = c;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 2) == 0)
         gap = pick_pause();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample_in <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_outputs.push_back(gate_predict(s));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // loud bursts followed by quiet tails walk the gate through open, hold and close
   task automatic run_bursts(input int n_items, input int quiet_max);
      int sent;
      int seg;
      int amp;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 3) == 0) begin
            seg = $urandom_range(1, 8);
            repeat (seg) send_sample(SAMPLE_WIDTH'($urandom));
            sent += seg;
         end else begin
            amp = $urandom_range(1000, 32768);
            seg = $urandom_range(1, 12);
            repeat (seg) send_sample(($urandom_range(0, 15) == 0) ? 16'sh8000
                                                                 : rand_sample(amp));
            sent += seg;
            amp = $urandom_range(0, 200);
            seg = $urandom_range(1, quiet_max);
            repeat (seg) send_sample(rand_sample(amp));
            sent += seg;
         end
      end
   endtask

   task automatic run_phase(input ngh_cfg_type c, input int n_items, input int quiet_max,
                            input bit gaps, input bit stalls);
      req_gaps_on = gaps;
      rsp_stalls_on = stalls;
      program_regs(c, 1'($urandom));
      run_bursts(n_items, quiet_max);
      wait_drained();
   endtask

   task automatic test_reset_defaults();
      send_sample(16'sd0);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      wait_drained();
   endtask

   // instant envelope and gain so the hold count is visible sample by sample
   task automatic test_hold_counts();
      ngh_cfg_type c;
      c = '{threshold_level: 16'd100, range_gain: 17'd0, attack_coeff: 16'd0,
            release_coeff: 16'd0, env_rise_coeff: 16'd0, env_fall_coeff: 16'd0,
            hold_samples: 16'd0};
      program_regs(c, 1'b0);
      send_sample(16'sd32767);
      send_sample(16'sd0);
      send_sample(-16'sd32768);
      send_sample(16'sd5);
      send_sample(-16'sd5);
      wait_drained();
      c.hold_samples = 16'd3;
      program_regs(c, 1'b0);
      send_sample(-16'sd20000);
      repeat (5) send_sample(16'sd7);
      send_sample(16'sd101);
      send_sample(-16'sd101);
      wait_drained();
   endtask

   task automatic test_unity_clamp_and_stray_write();
      ngh_cfg_type c;
      c = '{threshold_level: 16'hffff, range_gain: 17'h1ffff, attack_coeff: 16'd0,
            release_coeff: 16'd0, env_rise_coeff: 16'd65535, env_fall_coeff: 16'd65535,
            hold_samples: 16'hffff};
      program_regs(c, 1'b1);
      send_sample(-16'sd32768);
      send_sample(16'sd32767);
      send_sample(16'sd12345);
      wait_drained();
      c.range_gain = 17'h10000;
      program_regs(c, 1'b1);
      send_sample(-16'sd1);
      wait_drained();
   endtask

   task automatic test_random_phases();
      ngh_cfg_type c;
      run_phase(default_cfg(), 180, 30, 1'b1, 1'b1);
      c = '{threshold_level: 16'd1000, range_gain: 17'd0, attack_coeff: 16'd0,
            release_coeff: 16'd0, env_rise_coeff: 16'd0, env_fall_coeff: 16'd0,
            hold_samples: 16'd0};
      run_phase(c, 180, 6, 1'b0, 1'b0);
      c = '{threshold_level: 16'hffff, range_gain: 17'h1ffff, attack_coeff: 16'hffff,
            release_coeff: 16'hffff, env_rise_coeff: 16'hffff, env_fall_coeff: 16'hffff,
            hold_samples: 16'hffff};
      run_phase(c, 150, 20, 1'b1, 1'b0);
      c = '{threshold_level: 16'd0, range_gain: 17'h10000, attack_coeff: 16'd30000,
            release_coeff: 16'd50000, env_rise_coeff: 16'd2000, env_fall_coeff: 16'd60000,
            hold_samples: 16'd5};
      run_phase(c, 150, 20, 1'b0, 1'b1);
      repeat (5) run_phase(random_cfg(), 160, 40, 1'($urandom), 1'b1);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // output side: random back-pressure and in-order compare
   initial begin
      gated_sample_type exp_out;
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_outputs.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $error("unexpected output transfer: sample_out %0d gate_open %0d",
                         rsp_ch.sample_out, rsp_ch.gate_open);
               error_count++;
            end else begin
               exp_out = pending_outputs.pop_front();
               if (rsp_ch.sample_out !== exp_out.sample_out) begin
                  if (error_count < MAX_REPORTS)
                     $error("sample_out mismatch: expected %0d, got %0d",
                            exp_out.sample_out, rsp_ch.sample_out);
                  error_count++;
               end
               if (rsp_ch.gate_open !== exp_out.gate_open) begin
                  if (error_count < MAX_REPORTS)
                     $error("gate_open mismatch: expected %0d, got %0d",
                            exp_out.gate_open, rsp_ch.gate_open);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = pick_pause() - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.sample_in <= '0;
      gate_cfg = default_cfg();
      env_level = '0;
      gain_level = UNITY_GAIN;
      hold_cnt = '0;
      gate_is_open = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_hold_counts();
      test_unity_clamp_and_stray_write();
      test_random_phases();

      if (pending_outputs.size() != 0) begin
         $error("%0d expected outputs never arrived", pending_outputs.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
